/* sv/meteo_rof_pkg.sv */
// Shared types, constants and helper functions of the meteo report-on-change filter.
// Used by meteo_rof_prep, meteo_rof_core and the top level; depends on nothing.
`timescale 1ns / 1ps

package meteo_rof_pkg;

   localparam int TEMP_W     = 12;
   localparam int TCODE_W    = 13;
   localparam int HUM_W      = 10;
   localparam int PRES_W     = 14;
   localparam int TIME_W     = 32;
   localparam int EVT_W      = 8;
   localparam int THR_W      = 12;
   localparam int PACKED_W   = TCODE_W + HUM_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_CHECK  = 1'b1;

   localparam logic [EVT_W-1:0] EVT_TEMP_RISE = 8'h02;
   localparam logic [EVT_W-1:0] EVT_TEMP_FALL = 8'h03;
   localparam logic [EVT_W-1:0] EVT_HUM_RISE  = 8'h05;
   localparam logic [EVT_W-1:0] EVT_HUM_FALL  = 8'h06;

   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_DEADBAND = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HUM_DEADBAND  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PRES_DEADBAND = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REFRESH       = 2'd3;

   localparam logic [7:0]  TEMP_DEADBAND_RESET = 8'd2;
   localparam logic [7:0]  HUM_DEADBAND_RESET  = 8'd4;
   localparam logic [9:0]  PRES_DEADBAND_RESET = 10'd50;
   localparam logic [15:0] REFRESH_RESET       = 16'd60;

   localparam logic [TCODE_W-1:0]  SIGN_BIT      = 13'h1000;
   localparam logic signed [TEMP_W-1:0] TEMP_LIMIT = 12'sd2000;
   localparam logic [HUM_W-1:0]    HUM_LIMIT     = 10'd1000;
   localparam logic [PACKED_W-1:0] NOT_ANNOUNCED = '1;
   localparam logic [8:0]          OPERAND_ZERO  = 9'd127;

   // Checked and preprocessed item, handed from the input stage to the core.
   typedef struct packed {
      logic                      kind;
      logic                      on_grid;
      logic [TIME_W-1:0]         now;
      logic [TCODE_W-1:0]        tcode;
      logic [HUM_W-1:0]          hval;
      logic [PRES_W-1:0]         pres;
      logic                      ev_temp;
      logic                      ev_hum;
      logic                      ev_rise;
      logic signed [THR_W-1:0]   thr;
   } item_type;

   typedef struct packed {
      logic                  temperature_updated;
      logic                  humidity_updated;
      logic                  pressure_updated;
      logic                  announce;
      logic [TCODE_W-1:0]    temperature_code;
      logic [HUM_W-1:0]      humidity_code;
      logic [PRES_W-1:0]     pressure_code;
      logic                  event_true;
   } result_type;

   // 16 is 1 mod 5, so the nibble sum keeps the residue; two more folds bring
   // it to at most 15, where the multiples of five are checked directly.
   function automatic logic on_grid(logic [TIME_W-1:0] t);
      logic [6:0] sum1;
      logic [4:0] sum2;
      logic [3:0] sum3;
      sum1 = '0;
      for (int i = 0; i < TIME_W / 4; i++) begin
         sum1 = sum1 + {3'd0, t[4*i +: 4]};
      end
      sum2 = {2'd0, sum1[6:4]} + {1'b0, sum1[3:0]};
      sum3 = 4'(sum2[4]) + sum2[3:0];
      return (sum3 == 4'd0) || (sum3 == 4'd5) || (sum3 == 4'd10) || (sum3 == 4'd15);
   endfunction

   function automatic logic [TCODE_W-1:0] temp_code(logic signed [TEMP_W-1:0] t);
      logic signed [TEMP_W-1:0] sat;
      logic [TEMP_W-1:0]        mag;
      sat = t;
      if (t > TEMP_LIMIT) begin
         sat = TEMP_LIMIT;
      end else if (t < -TEMP_LIMIT) begin
         sat = -TEMP_LIMIT;
      end
      mag = sat[TEMP_W-1] ? TEMP_W'(-sat) : TEMP_W'(sat);
      return sat[TEMP_W-1] ? (SIGN_BIT | {1'b0, mag}) : {1'b0, mag};
   endfunction

   function automatic logic signed [TCODE_W-1:0] code_tenths(logic [TCODE_W-1:0] c);
      logic signed [TCODE_W-1:0] mag;
      mag = $signed({1'b0, c[TCODE_W-2:0]});
      return c[TCODE_W-1] ? -mag : mag;
   endfunction

   function automatic logic [PRES_W-1:0] abs_diff(logic [PRES_W-1:0] a, logic [PRES_W-1:0] b);
      return (a >= b) ? (a - b) : (b - a);
   endfunction

endpackage

/* sv/meteo_report_on_change_filter_unit.sv */
// Top level of the meteo report-on-change filter.
// Instantiates meteo_rof_prep and meteo_rof_core; uses meteo_rof_pkg.
`timescale 1ns / 1ps

// Takes one request beat per clock and returns exactly one response beat for
// each, in order. An accepted request is held in the input register (grid
// check on uptime, temperature saturation and sign-magnitude coding, threshold
// scaling); the decision stage then compares and replaces the stored channel
// values and captures the response in the result register, which drives
// rsp_valid. Stored state is read and written in that single stage, so
// back-to-back beats always see the effect of the beat before them and the
// sustained rate is one beat per cycle while rsp_stall stays low. A stalled
// response holds the input register, and req_stall follows rsp_stall in the
// same cycle. Registers are written through the csr_ port and should change
// only while no beat is in flight.

module meteo_report_on_change_filter_unit (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_write_enable,
   input  logic [meteo_rof_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [meteo_rof_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic                                     req_kind,
   input  logic [meteo_rof_pkg::TIME_W-1:0]         req_uptime_seconds,
   input  logic signed [meteo_rof_pkg::TEMP_W-1:0]  req_temperature_tenths,
   input  logic [meteo_rof_pkg::HUM_W-1:0]          req_humidity_tenths,
   input  logic [meteo_rof_pkg::PRES_W-1:0]         req_pressure_tenths,
   input  logic [meteo_rof_pkg::EVT_W-1:0]          req_event_code,
   input  logic [7:0]                               req_event_operand,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic                                     rsp_temperature_updated,
   output logic                                     rsp_humidity_updated,
   output logic                                     rsp_pressure_updated,
   output logic                                     rsp_announce,
   output logic [meteo_rof_pkg::TCODE_W-1:0]        rsp_temperature_code,
   output logic [meteo_rof_pkg::HUM_W-1:0]          rsp_humidity_code,
   output logic [meteo_rof_pkg::PRES_W-1:0]         rsp_pressure_code,
   output logic                                     rsp_event_true
);

   logic                      item_valid;
   logic                      item_ready;
   meteo_rof_pkg::item_type   item;
   meteo_rof_pkg::result_type rsp;

   meteo_rof_prep u_prep (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_kind               (req_kind),
      .req_uptime_seconds     (req_uptime_seconds),
      .req_temperature_tenths (req_temperature_tenths),
      .req_humidity_tenths    (req_humidity_tenths),
      .req_pressure_tenths    (req_pressure_tenths),
      .req_event_code         (req_event_code),
      .req_event_operand      (req_event_operand),
      .item_valid             (item_valid),
      .item                   (item),
      .item_ready             (item_ready)
   );

   meteo_rof_core u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .item_valid       (item_valid),
      .item             (item),
      .item_ready       (item_ready),
      .rsp_valid        (rsp_valid),
      .rsp              (rsp),
      .rsp_stall        (rsp_stall)
   );

   assign rsp_temperature_updated = rsp.temperature_updated;
   assign rsp_humidity_updated    = rsp.humidity_updated;
   assign rsp_pressure_updated    = rsp.pressure_updated;
   assign rsp_announce            = rsp.announce;
   assign rsp_temperature_code    = rsp.temperature_code;
   assign rsp_humidity_code       = rsp.humidity_code;
   assign rsp_pressure_code       = rsp.pressure_code;
   assign rsp_event_true          = rsp.event_true;

endmodule

/* sv/meteo_rof_prep.sv */
// Input stage of the meteo report-on-change filter: registers one request beat,
// with the grid check, saturation, event decode and threshold. Uses meteo_rof_pkg.
`timescale 1ns / 1ps

module meteo_rof_prep (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_kind,
   input  logic [meteo_rof_pkg::TIME_W-1:0]       req_uptime_seconds,
   input  logic signed [meteo_rof_pkg::TEMP_W-1:0] req_temperature_tenths,
   input  logic [meteo_rof_pkg::HUM_W-1:0]        req_humidity_tenths,
   input  logic [meteo_rof_pkg::PRES_W-1:0]       req_pressure_tenths,
   input  logic [meteo_rof_pkg::EVT_W-1:0]        req_event_code,
   input  logic [7:0]                             req_event_operand,
   output logic                                   item_valid,
   output meteo_rof_pkg::item_type                item,
   input  logic                                   item_ready
);

   logic                    item_valid_ff;
   logic                    item_valid_in;
   meteo_rof_pkg::item_type item_ff;
   meteo_rof_pkg::item_type item_in;
   logic signed [8:0]       offset;
   logic                    load;

   assign req_stall = item_valid_ff && !item_ready;
   assign load      = req_valid && !req_stall;
   assign item_valid_in = req_stall ? item_valid_ff : req_valid;

   always_comb begin
      offset          = $signed({1'b0, req_event_operand}) - $signed(meteo_rof_pkg::OPERAND_ZERO);
      item_in.kind    = req_kind;
      item_in.on_grid = meteo_rof_pkg::on_grid(req_uptime_seconds);
      item_in.now     = req_uptime_seconds;
      item_in.tcode   = meteo_rof_pkg::temp_code(req_temperature_tenths);
      item_in.hval    = (req_humidity_tenths > meteo_rof_pkg::HUM_LIMIT) ?
                        meteo_rof_pkg::HUM_LIMIT : req_humidity_tenths;
      item_in.pres    = req_pressure_tenths;
      item_in.ev_temp = (req_event_code == meteo_rof_pkg::EVT_TEMP_RISE) ||
                        (req_event_code == meteo_rof_pkg::EVT_TEMP_FALL);
      item_in.ev_hum  = (req_event_code == meteo_rof_pkg::EVT_HUM_RISE) ||
                        (req_event_code == meteo_rof_pkg::EVT_HUM_FALL);
      item_in.ev_rise = (req_event_code == meteo_rof_pkg::EVT_TEMP_RISE) ||
                        (req_event_code == meteo_rof_pkg::EVT_HUM_RISE);
      // Threshold in tenths: offset times ten as two shifted copies.
      item_in.thr     = (meteo_rof_pkg::THR_W'(offset) <<< 3) +
                        (meteo_rof_pkg::THR_W'(offset) <<< 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = item_valid_ff;
   assign item       = item_ff;

endmodule

/* sv/meteo_rof_core.sv */
// Decision stage of the meteo report-on-change filter: configuration registers,
// stored channel state, update and event logic, and the result register. Uses meteo_rof_pkg.
`timescale 1ns / 1ps

module meteo_rof_core (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_write_enable,
   input  logic [meteo_rof_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [meteo_rof_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  logic                                     item_valid,
   input  meteo_rof_pkg::item_type                  item,
   output logic                                     item_ready,
   output logic                                     rsp_valid,
   output meteo_rof_pkg::result_type                rsp,
   input  logic                                     rsp_stall
);

   logic [7:0]  t_band_ff;
   logic [7:0]  h_band_ff;
   logic [9:0]  p_band_ff;
   logic [15:0] refresh_ff;

   logic [meteo_rof_pkg::TCODE_W-1:0]  cur_t_ff, cur_t_in, old_t_ff;
   logic [meteo_rof_pkg::HUM_W-1:0]    cur_h_ff, cur_h_in, old_h_ff;
   logic [meteo_rof_pkg::PRES_W-1:0]   cur_p_ff, cur_p_in;
   logic [meteo_rof_pkg::TIME_W-1:0]   t_stamp_ff, h_stamp_ff, p_stamp_ff;
   logic [meteo_rof_pkg::PACKED_W-1:0] announced_ff, packed_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   meteo_rof_pkg::result_type rsp_ff, rsp_in;

   logic fire, sample, check;
   logic t_store, h_store, p_store;
   logic t_upd, h_upd, p_upd, ann, ev;
   logic [meteo_rof_pkg::TIME_W-1:0] t_dt, h_dt, p_dt, refresh_wide;
   logic signed [meteo_rof_pkg::TCODE_W-1:0] prev_val, cur_val, thr_wide;
   logic rise_hit, fall_hit;

   assign item_ready   = !rsp_valid_ff || !rsp_stall;
   assign fire         = item_valid && item_ready;
   assign rsp_valid_in = item_ready ? item_valid : rsp_valid_ff;

   always_comb begin
      sample       = (item.kind == meteo_rof_pkg::KIND_SAMPLE) && item.on_grid;
      check        = (item.kind == meteo_rof_pkg::KIND_CHECK);
      refresh_wide = {16'd0, refresh_ff};
      t_dt         = item.now - t_stamp_ff;
      h_dt         = item.now - h_stamp_ff;
      p_dt         = item.now - p_stamp_ff;

      // On an on-grid sample, a channel holds its value only while the change is
      // inside the deadband and the refresh interval has not run out.
      t_store = !((meteo_rof_pkg::abs_diff({1'b0, item.tcode}, {1'b0, cur_t_ff}) <
                   {6'd0, t_band_ff}) && (t_dt < refresh_wide));
      h_store = !((meteo_rof_pkg::abs_diff({4'd0, item.hval}, {4'd0, cur_h_ff}) <
                   {6'd0, h_band_ff}) && (h_dt < refresh_wide));
      p_store = !((meteo_rof_pkg::abs_diff(item.pres, cur_p_ff) <
                   {4'd0, p_band_ff}) && (p_dt < refresh_wide));

      t_upd = sample && t_store;
      h_upd = sample && h_store;
      p_upd = sample && p_store;

      cur_t_in  = t_upd ? item.tcode : cur_t_ff;
      cur_h_in  = h_upd ? item.hval  : cur_h_ff;
      cur_p_in  = p_upd ? item.pres  : cur_p_ff;
      packed_in = {cur_t_in, cur_h_in};
      ann       = (t_upd || h_upd) && (packed_in != announced_ff);

      thr_wide = {item.thr[meteo_rof_pkg::THR_W-1], item.thr};
      if (item.ev_temp) begin
         prev_val = meteo_rof_pkg::code_tenths(old_t_ff);
         cur_val  = meteo_rof_pkg::code_tenths(cur_t_ff);
      end else begin
         prev_val = $signed({3'd0, old_h_ff});
         cur_val  = $signed({3'd0, cur_h_ff});
      end
      rise_hit = (prev_val <= thr_wide) && (cur_val > thr_wide);
      fall_hit = (prev_val >= thr_wide) && (cur_val < thr_wide);
      ev = check && (item.ev_temp || item.ev_hum) && (item.ev_rise ? rise_hit : fall_hit);

      rsp_in.temperature_updated = t_upd;
      rsp_in.humidity_updated    = h_upd;
      rsp_in.pressure_updated    = p_upd;
      rsp_in.announce            = ann;
      rsp_in.temperature_code    = cur_t_in;
      rsp_in.humidity_code       = cur_h_in;
      rsp_in.pressure_code       = cur_p_in;
      rsp_in.event_true          = ev;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t_band_ff    <= meteo_rof_pkg::TEMP_DEADBAND_RESET;
         h_band_ff    <= meteo_rof_pkg::HUM_DEADBAND_RESET;
         p_band_ff    <= meteo_rof_pkg::PRES_DEADBAND_RESET;
         refresh_ff   <= meteo_rof_pkg::REFRESH_RESET;
         cur_t_ff     <= '0;
         cur_h_ff     <= '0;
         cur_p_ff     <= '0;
         old_t_ff     <= '0;
         old_h_ff     <= '0;
         t_stamp_ff   <= '0;
         h_stamp_ff   <= '0;
         p_stamp_ff   <= '0;
         announced_ff <= meteo_rof_pkg::NOT_ANNOUNCED;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               meteo_rof_pkg::CSR_TEMP_DEADBAND: t_band_ff  <= csr_write_data[7:0];
               meteo_rof_pkg::CSR_HUM_DEADBAND:  h_band_ff  <= csr_write_data[7:0];
               meteo_rof_pkg::CSR_PRES_DEADBAND: p_band_ff  <= csr_write_data[9:0];
               meteo_rof_pkg::CSR_REFRESH:       refresh_ff <= csr_write_data;
               default: ;
            endcase
         end
         if (fire) begin
            if (t_upd) begin
               t_stamp_ff <= item.now;
               old_t_ff   <= cur_t_ff;
            end
            if (h_upd) begin
               h_stamp_ff <= item.now;
               old_h_ff   <= cur_h_ff;
            end
            if (p_upd) begin
               p_stamp_ff <= item.now;
            end
            cur_t_ff <= cur_t_in;
            cur_h_ff <= cur_h_in;
            cur_p_ff <= cur_p_in;
            if (ann) begin
               announced_ff <= packed_in;
            end
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   a_announce_needs_update: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.announce |->
         rsp_ff.temperature_updated || rsp_ff.humidity_updated)
      else $error("announce raised without a temperature or humidity update");

   a_announce_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.announce |->
         announced_ff == {rsp_ff.temperature_code, rsp_ff.humidity_code})
      else $error("announced code does not match the result codes");

   a_event_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.event_true |->
         !(rsp_ff.temperature_updated || rsp_ff.humidity_updated ||
           rsp_ff.pressure_updated || rsp_ff.announce))
      else $error("event result also reports an update");

   a_result_tracks_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.temperature_code == cur_t_ff) &&
                       (rsp_ff.humidity_code == cur_h_ff) &&
                       (rsp_ff.pressure_code == cur_p_ff))
      else $error("held result disagrees with stored channel values");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(cur_t_ff) && $stable(cur_h_ff) && $stable(announced_ff))
      else $error("channel state changed without an accepted beat");

endmodule

/* test/meteo_rof_checker.sv */
// Watches the request, response and register ports of the meteo report-on-change filter,
// predicts every response beat and compares it field by field. Uses meteo_rof_pkg.
`timescale 1ns / 1ps

module meteo_rof_checker (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_write_enable,
   input  logic [meteo_rof_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [meteo_rof_pkg::CSR_DATA_W-1:0]    csr_write_data,
   input  logic                                    req_valid,
   input  logic                                    req_stall,
   input  logic                                    req_kind,
   input  logic [meteo_rof_pkg::TIME_W-1:0]        req_uptime_seconds,
   input  logic signed [meteo_rof_pkg::TEMP_W-1:0] req_temperature_tenths,
   input  logic [meteo_rof_pkg::HUM_W-1:0]         req_humidity_tenths,
   input  logic [meteo_rof_pkg::PRES_W-1:0]        req_pressure_tenths,
   input  logic [meteo_rof_pkg::EVT_W-1:0]         req_event_code,
   input  logic [7:0]                              req_event_operand,
   input  logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   input  logic                                    rsp_temperature_updated,
   input  logic                                    rsp_humidity_updated,
   input  logic                                    rsp_pressure_updated,
   input  logic                                    rsp_announce,
   input  logic [meteo_rof_pkg::TCODE_W-1:0]       rsp_temperature_code,
   input  logic [meteo_rof_pkg::HUM_W-1:0]         rsp_humidity_code,
   input  logic [meteo_rof_pkg::PRES_W-1:0]        rsp_pressure_code,
   input  logic                                    rsp_event_true,
   output int                                      mismatch_count,
   output int                                      reports_pending,
   output int                                      reports_checked,
   output int                                      announce_seen,
   output int                                      crossings_seen
);

   localparam logic [meteo_rof_pkg::TIME_W-1:0] GRID_SECONDS = 32'd5;
   localparam int                               REPORT_LIMIT = 10;

   logic [7:0]  temp_band = meteo_rof_pkg::TEMP_DEADBAND_RESET;
   logic [7:0]  hum_band = meteo_rof_pkg::HUM_DEADBAND_RESET;
   logic [9:0]  pres_band = meteo_rof_pkg::PRES_DEADBAND_RESET;
   logic [15:0] refresh_s = meteo_rof_pkg::REFRESH_RESET;

   logic [meteo_rof_pkg::TCODE_W-1:0]  temp_held = '0;
   logic [meteo_rof_pkg::TCODE_W-1:0]  temp_prior = '0;
   logic [meteo_rof_pkg::HUM_W-1:0]    hum_held = '0;
   logic [meteo_rof_pkg::HUM_W-1:0]    hum_prior = '0;
   logic [meteo_rof_pkg::PRES_W-1:0]   pres_held = '0;
   logic [meteo_rof_pkg::TIME_W-1:0]   temp_stamp = '0;
   logic [meteo_rof_pkg::TIME_W-1:0]   hum_stamp = '0;
   logic [meteo_rof_pkg::TIME_W-1:0]   pres_stamp = '0;
   logic [meteo_rof_pkg::PACKED_W-1:0] last_announced = meteo_rof_pkg::NOT_ANNOUNCED;

   meteo_rof_pkg::result_type pending_reports[$];

   // Saturate to +/-200.0 degrees and build the sign-magnitude code.
   function automatic logic [meteo_rof_pkg::TCODE_W-1:0] encode_temperature(
      logic signed [meteo_rof_pkg::TEMP_W-1:0] t);
      int v;
      int lim;
      v = t;
      lim = meteo_rof_pkg::TEMP_LIMIT;
      if (v > lim) v = lim;
      if (v < -lim) v = -lim;
      return (v < 0) ? (meteo_rof_pkg::SIGN_BIT | meteo_rof_pkg::TCODE_W'(-v)) :
                       meteo_rof_pkg::TCODE_W'(v);
   endfunction

   function automatic int tenths_of(logic [meteo_rof_pkg::TCODE_W-1:0] code);
      int mag;
      mag = code[meteo_rof_pkg::TCODE_W-2:0];
      return code[meteo_rof_pkg::TCODE_W-1] ? -mag : mag;
   endfunction

   // A channel keeps its old value only when the change is inside the deadband
   // and the refresh interval has not yet run out (elapsed time wraps at 2^32).
   function automatic bit change_suppressed(int unsigned fresh, int unsigned held,
                                            int unsigned band,
                                            logic [meteo_rof_pkg::TIME_W-1:0] now,
                                            logic [meteo_rof_pkg::TIME_W-1:0] stamp);
      logic [meteo_rof_pkg::TIME_W-1:0] elapsed;
      int unsigned                      delta;
      elapsed = now - stamp;
      delta = (fresh >= held) ? fresh - held : held - fresh;
      return (delta < band) && (elapsed < {16'd0, refresh_s});
   endfunction

   function automatic bit crossing(int prev, int cur, int thr, bit rise);
      if (rise) return (prev <= thr) && (cur > thr);
      return (prev >= thr) && (cur < thr);
   endfunction

   task automatic apply_reading();
      meteo_rof_pkg::result_type          r;
      logic [meteo_rof_pkg::TCODE_W-1:0]  tc;
      logic [meteo_rof_pkg::HUM_W-1:0]    hv;
      logic [meteo_rof_pkg::PACKED_W-1:0] pair_code;
      int                                 thr;
      r = '0;
      if (req_kind == meteo_rof_pkg::KIND_SAMPLE) begin
         if (req_uptime_seconds % GRID_SECONDS == 0) begin
            tc = encode_temperature(req_temperature_tenths);
            hv = (req_humidity_tenths > meteo_rof_pkg::HUM_LIMIT) ?
                 meteo_rof_pkg::HUM_LIMIT : req_humidity_tenths;
            if (!change_suppressed(tc, temp_held, temp_band, req_uptime_seconds,
                                   temp_stamp)) begin
               temp_stamp = req_uptime_seconds;
               temp_prior = temp_held;
               temp_held = tc;
               r.temperature_updated = 1'b1;
            end
            if (!change_suppressed(hv, hum_held, hum_band, req_uptime_seconds,
                                   hum_stamp)) begin
               hum_stamp = req_uptime_seconds;
               hum_prior = hum_held;
               hum_held = hv;
               r.humidity_updated = 1'b1;
            end
            if (!change_suppressed(req_pressure_tenths, pres_held, pres_band,
                                   req_uptime_seconds, pres_stamp)) begin
               pres_stamp = req_uptime_seconds;
               pres_held = req_pressure_tenths;
               r.pressure_updated = 1'b1;
            end
            pair_code = {temp_held, hum_held};
            if ((r.temperature_updated || r.humidity_updated) &&
                pair_code != last_announced) begin
               last_announced = pair_code;
               r.announce = 1'b1;
            end
         end
      end else begin
         thr = (int'(req_event_operand) - int'(meteo_rof_pkg::OPERAND_ZERO)) * 10;
         case (req_event_code)
            meteo_rof_pkg::EVT_TEMP_RISE, meteo_rof_pkg::EVT_TEMP_FALL: begin
               r.event_true = crossing(tenths_of(temp_prior), tenths_of(temp_held), thr,
                                       req_event_code == meteo_rof_pkg::EVT_TEMP_RISE);
            end
            meteo_rof_pkg::EVT_HUM_RISE, meteo_rof_pkg::EVT_HUM_FALL: begin
               r.event_true = crossing(int'(hum_prior), int'(hum_held), thr,
                                       req_event_code == meteo_rof_pkg::EVT_HUM_RISE);
            end
            default: ;
         endcase
      end
      r.temperature_code = temp_held;
      r.humidity_code = hum_held;
      r.pressure_code = pres_held;
      pending_reports.push_back(r);
   endtask

   task automatic compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: beat %0d field %s expected %0d got %0d",
                     $realtime, reports_checked, name, want, got);
         end
      end
   endtask

   task automatic match_report();
      meteo_rof_pkg::result_type want;
      if (pending_reports.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: response beat with no request outstanding", $realtime);
         end
      end else begin
         want = pending_reports.pop_front();
         compare_field("temperature_updated", want.temperature_updated,
                       rsp_temperature_updated);
         compare_field("humidity_updated", want.humidity_updated, rsp_humidity_updated);
         compare_field("pressure_updated", want.pressure_updated, rsp_pressure_updated);
         compare_field("announce", want.announce, rsp_announce);
         compare_field("temperature_code", want.temperature_code, rsp_temperature_code);
         compare_field("humidity_code", want.humidity_code, rsp_humidity_code);
         compare_field("pressure_code", want.pressure_code, rsp_pressure_code);
         compare_field("event_true", want.event_true, rsp_event_true);
      end
      reports_checked++;
      announce_seen += rsp_announce;
      crossings_seen += rsp_event_true;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         temp_band = meteo_rof_pkg::TEMP_DEADBAND_RESET;
         hum_band = meteo_rof_pkg::HUM_DEADBAND_RESET;
         pres_band = meteo_rof_pkg::PRES_DEADBAND_RESET;
         refresh_s = meteo_rof_pkg::REFRESH_RESET;
         temp_held = '0;
         temp_prior = '0;
         hum_held = '0;
         hum_prior = '0;
         pres_held = '0;
         temp_stamp = '0;
         hum_stamp = '0;
         pres_stamp = '0;
         last_announced = meteo_rof_pkg::NOT_ANNOUNCED;
         pending_reports.delete();
         mismatch_count = 0;
         reports_checked = 0;
         announce_seen = 0;
         crossings_seen = 0;
      end else begin
         if (rsp_valid && !rsp_stall) match_report();
         if (req_valid && !req_stall) apply_reading();
         if (csr_write_enable) begin
            case (csr_index)
               meteo_rof_pkg::CSR_TEMP_DEADBAND: temp_band = csr_write_data[7:0];
               meteo_rof_pkg::CSR_HUM_DEADBAND:  hum_band = csr_write_data[7:0];
               meteo_rof_pkg::CSR_PRES_DEADBAND: pres_band = csr_write_data[9:0];
               meteo_rof_pkg::CSR_REFRESH:       refresh_s = csr_write_data;
               default: ;
            endcase
         end
      end
      reports_pending = pending_reports.size();
   end

endmodule

/* test/meteo_report_on_change_filter_unit_tb.sv */
// Stimulus and verdict for the meteo report-on-change filter: directed corner beats, then
// random sample and scene-check traffic under several register settings and stall patterns.
// Depends on meteo_rof_pkg, meteo_report_on_change_filter_unit and meteo_rof_checker.
`timescale 1ns / 1ps

module meteo_report_on_change_filter_unit_tb;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASES       = 6;
   localparam int PHASE_BEATS  = 100;

   logic                                    clock = 1'b0;
   logic                                    reset = 1'b1;
   logic                                    csr_write_enable = 1'b0;
   logic [meteo_rof_pkg::CSR_IDX_W-1:0]     csr_index = meteo_rof_pkg::CSR_TEMP_DEADBAND;
   logic [meteo_rof_pkg::CSR_DATA_W-1:0]    csr_write_data = '0;
   logic                                    req_valid = 1'b0;
   logic                                    req_stall;
   logic                                    req_kind = meteo_rof_pkg::KIND_SAMPLE;
   logic [meteo_rof_pkg::TIME_W-1:0]        req_uptime_seconds = '0;
   logic signed [meteo_rof_pkg::TEMP_W-1:0] req_temperature_tenths = '0;
   logic [meteo_rof_pkg::HUM_W-1:0]         req_humidity_tenths = '0;
   logic [meteo_rof_pkg::PRES_W-1:0]        req_pressure_tenths = '0;
   logic [meteo_rof_pkg::EVT_W-1:0]         req_event_code = '0;
   logic [7:0]                              req_event_operand = '0;
   logic                                    rsp_valid;
   logic                                    rsp_stall = 1'b0;
   logic                                    rsp_temperature_updated;
   logic                                    rsp_humidity_updated;
   logic                                    rsp_pressure_updated;
   logic                                    rsp_announce;
   logic [meteo_rof_pkg::TCODE_W-1:0]       rsp_temperature_code;
   logic [meteo_rof_pkg::HUM_W-1:0]         rsp_humidity_code;
   logic [meteo_rof_pkg::PRES_W-1:0]        rsp_pressure_code;
   logic                                    rsp_event_true;

   int mismatch_count;
   int reports_pending;
   int reports_checked;
   int announce_seen;
   int crossings_seen;
   int cycle_count = 0;
   int send_idle_pct = 15;
   int sink_stall_pct = 79;

   meteo_report_on_change_filter_unit DUT (
      .clock                  (clock),
      .reset                  (reset),
      .csr_write_enable       (csr_write_enable),
      .csr_index              (csr_index),
      .csr_write_data         (csr_write_data),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_kind               (req_kind),
      .req_uptime_seconds     (req_uptime_seconds),
      .req_temperature_tenths (req_temperature_tenths),
      .req_humidity_tenths    (req_humidity_tenths),
      .req_pressure_tenths    (req_pressure_tenths),
      .req_event_code         (req_event_code),
      .req_event_operand      (req_event_operand),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_temperature_updated(rsp_temperature_updated),
      .rsp_humidity_updated   (rsp_humidity_updated),
      .rsp_pressure_updated   (rsp_pressure_updated),
      .rsp_announce           (rsp_announce),
      .rsp_temperature_code   (rsp_temperature_code),
      .rsp_humidity_code      (rsp_humidity_code),
      .rsp_pressure_code      (rsp_pressure_code),
      .rsp_event_true         (rsp_event_true)
   );

   meteo_rof_checker u_checker (
      .clock                  (clock),
      .reset                  (reset),
      .csr_write_enable       (csr_write_enable),
      .csr_index              (csr_index),
      .csr_write_data         (csr_write_data),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_kind               (req_kind),
      .req_uptime_seconds     (req_uptime_seconds),
      .req_temperature_tenths (req_temperature_tenths),
      .req_humidity_tenths    (req_humidity_tenths),
      .req_pressure_tenths    (req_pressure_tenths),
      .req_event_code         (req_event_code),
      .req_event_operand      (req_event_operand),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_temperature_updated(rsp_temperature_updated),
      .rsp_humidity_updated   (rsp_humidity_updated),
      .rsp_pressure_updated   (rsp_pressure_updated),
      .rsp_announce           (rsp_announce),
      .rsp_temperature_code   (rsp_temperature_code),
      .rsp_humidity_code      (rsp_humidity_code),
      .rsp_pressure_code      (rsp_pressure_code),
      .rsp_event_true         (rsp_event_true),
      .mismatch_count         (mismatch_count),
      .reports_pending        (reports_pending),
      .reports_checked        (reports_checked),
      .announce_seen          (announce_seen),
      .crossings_seen         (crossings_seen)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < sink_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("run stopped after %0d cycles with %0d beats outstanding",
                  cycle_count, reports_pending);
         $display("TB_ERROR");
         $finish;
      end
   end

   // Valid is left high after the accepting edge; the next beat either replaces the
   // payload in place or drops valid for its idle cycles.
   task automatic send_beat(logic kind, logic [meteo_rof_pkg::TIME_W-1:0] up,
                            logic signed [meteo_rof_pkg::TEMP_W-1:0] t,
                            logic [meteo_rof_pkg::HUM_W-1:0] h,
                            logic [meteo_rof_pkg::PRES_W-1:0] p,
                            logic [meteo_rof_pkg::EVT_W-1:0] code, logic [7:0] op);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_uptime_seconds <= up;
      req_temperature_tenths <= t;
      req_humidity_tenths <= h;
      req_pressure_tenths <= p;
      req_event_code <= code;
      req_event_operand <= op;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (reports_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [meteo_rof_pkg::CSR_IDX_W-1:0] idx,
                            logic [meteo_rof_pkg::CSR_DATA_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
   endtask

   task automatic write_settings(int tband, int hband, int pband, int refresh);
      write_reg(meteo_rof_pkg::CSR_TEMP_DEADBAND, meteo_rof_pkg::CSR_DATA_W'(tband));
      write_reg(meteo_rof_pkg::CSR_HUM_DEADBAND, meteo_rof_pkg::CSR_DATA_W'(hband));
      write_reg(meteo_rof_pkg::CSR_PRES_DEADBAND, meteo_rof_pkg::CSR_DATA_W'(pband));
      write_reg(meteo_rof_pkg::CSR_REFRESH, meteo_rof_pkg::CSR_DATA_W'(refresh));
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      logic [meteo_rof_pkg::TIME_W-1:0] uptime;
      logic [meteo_rof_pkg::EVT_W-1:0]  code;
      int                               walk_t, prior_t, walk_h, prior_h, walk_p;
      int                               sel, op;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats under the reset register values.
      send_beat(meteo_rof_pkg::KIND_SAMPLE, 32'd0, 12'sd0, 10'd0, 14'd0, 8'd0, 8'd0);
      // Off the five-second grid: nothing may change.
      send_beat(meteo_rof_pkg::KIND_SAMPLE, 32'd3, 12'sh7FF, 10'h3FF, 14'h3FFF, 8'hFF,
                8'hFF);
      // Full-scale values saturate to +200.0 degrees and 100.0 percent.
      send_beat(meteo_rof_pkg::KIND_SAMPLE, 32'd5, 12'sh7FF, 10'h3FF, 14'h3FFF, 8'd0, 8'd0);
      send_beat(meteo_rof_pkg::KIND_CHECK, 32'd0, 12'sd0, 10'd0, 14'd0,
                meteo_rof_pkg::EVT_TEMP_RISE, 8'd227);
      send_beat(meteo_rof_pkg::KIND_CHECK, 32'd0, 12'sd0, 10'd0, 14'd0,
                meteo_rof_pkg::EVT_HUM_RISE, 8'd177);
      send_beat(meteo_rof_pkg::KIND_SAMPLE, 32'd10, 12'sh800, 10'd0, 14'd0, 8'd0, 8'd0);
      send_beat(meteo_rof_pkg::KIND_CHECK, 32'd0, 12'sd0, 10'd0, 14'd0,
                meteo_rof_pkg::EVT_TEMP_FALL, 8'd127);
      send_beat(meteo_rof_pkg::KIND_CHECK, 32'd0, 12'sd0, 10'd0, 14'd0,
                meteo_rof_pkg::EVT_HUM_FALL, 8'd177);
      send_beat(meteo_rof_pkg::KIND_CHECK, 32'hFFFF_FFFF, 12'sh7FF, 10'h3FF, 14'h3FFF,
                8'hFF, 8'hFF);
      send_beat(meteo_rof_pkg::KIND_CHECK, 32'd0, 12'sd0, 10'd0, 14'd0, 8'h00, 8'h00);
      // Every change inside its deadband: all three channels hold.
      send_beat(meteo_rof_pkg::KIND_SAMPLE, 32'd15, -12'sd1999, 10'd3, 14'd49, 8'd0, 8'd0);
      send_beat(meteo_rof_pkg::KIND_CHECK, 32'd0, 12'sd0, 10'd0, 14'd0,
                meteo_rof_pkg::EVT_TEMP_RISE, 8'd0);
      // Crossing zero is a large step in sign-magnitude code.
      send_beat(meteo_rof_pkg::KIND_SAMPLE, 32'd20, 12'sd1, 10'd4, 14'd50, 8'd0, 8'd0);
      send_beat(meteo_rof_pkg::KIND_CHECK, 32'd0, 12'sd0, 10'd0, 14'd0,
                meteo_rof_pkg::EVT_TEMP_RISE, 8'd127);
      // Refresh interval reached with unchanged values: stored, but no announcement.
      send_beat(meteo_rof_pkg::KIND_SAMPLE, 32'd80, 12'sd1, 10'd4, 14'd50, 8'd0, 8'd0);
      send_beat(meteo_rof_pkg::KIND_SAMPLE, 32'hFFFF_FFFF, 12'sd2001, 10'd1001, 14'd8191,
                8'd0, 8'd0);
      // Elapsed time wraps through zero and stays short.
      send_beat(meteo_rof_pkg::KIND_SAMPLE, 32'd0, 12'sd2000, 10'd999, 14'd8190, 8'd0, 8'd0);
      send_beat(meteo_rof_pkg::KIND_CHECK, 32'd0, 12'sd0, 10'd0, 14'd0,
                meteo_rof_pkg::EVT_HUM_FALL, 8'd255);
      send_beat(meteo_rof_pkg::KIND_CHECK, 32'd0, 12'sd0, 10'd0, 14'd0,
                meteo_rof_pkg::EVT_HUM_RISE, 8'd0);
      send_beat(meteo_rof_pkg::KIND_SAMPLE, 32'd25, -12'sd1, 10'd500, 14'd0, 8'd0, 8'd0);
      send_beat(meteo_rof_pkg::KIND_CHECK, 32'd0, 12'sd0, 10'd0, 14'd0,
                meteo_rof_pkg::EVT_TEMP_FALL, 8'd127);

      uptime = 32'd100;
      walk_t = 200;
      prior_t = 200;
      walk_h = 500;
      prior_h = 500;
      walk_p = 8000;
      for (int phase = 0; phase < PHASES; phase++) begin
         drain();
         case (phase / 2)
            0: begin send_idle_pct = 15; sink_stall_pct = 79; end
            1: begin send_idle_pct = 79; sink_stall_pct = 15; end
            default: begin send_idle_pct = 0; sink_stall_pct = 0; end
         endcase
         case (phase)
            0: write_settings(0, 0, 0, 0);
            2: write_settings(255, 255, 1023, 65535);
            4: write_settings(meteo_rof_pkg::TEMP_DEADBAND_RESET,
                              meteo_rof_pkg::HUM_DEADBAND_RESET,
                              meteo_rof_pkg::PRES_DEADBAND_RESET,
                              meteo_rof_pkg::REFRESH_RESET);
            default: write_settings($urandom_range(1, 20), $urandom_range(1, 40),
                                    $urandom_range(1, 200), $urandom_range(10, 300));
         endcase

         for (int n = 0; n < PHASE_BEATS; n++) begin
            sel = $urandom_range(99);
            if (sel < 70) begin
               // Well-formed sample on the grid, mostly a small step from the last one.
               case ($urandom_range(19))
                  0: begin uptime = $urandom; uptime = uptime - uptime % 5; end
                  1: uptime = uptime + 5 * $urandom_range(5, 30);
                  default: uptime = uptime + 5 * $urandom_range(0, 4);
               endcase
               prior_t = walk_t;
               case ($urandom_range(9))
                  0: walk_t = $signed(12'($urandom));
                  1: walk_t = int'($urandom_range(20)) - 10;
                  default: walk_t = walk_t + int'($urandom_range(30)) - 15;
               endcase
               if (walk_t > 2047) walk_t = 2047;
               if (walk_t < -2048) walk_t = -2048;
               prior_h = walk_h;
               if ($urandom_range(9) == 0) walk_h = 10'($urandom);
               else walk_h = walk_h + int'($urandom_range(16)) - 8;
               if (walk_h > 1023) walk_h = 1023;
               if (walk_h < 0) walk_h = 0;
               if ($urandom_range(9) == 0) walk_p = 14'($urandom);
               else walk_p = walk_p + int'($urandom_range(160)) - 80;
               if (walk_p > 16383) walk_p = 16383;
               if (walk_p < 0) walk_p = 0;
               send_beat(meteo_rof_pkg::KIND_SAMPLE, uptime,
                         meteo_rof_pkg::TEMP_W'(walk_t), meteo_rof_pkg::HUM_W'(walk_h),
                         meteo_rof_pkg::PRES_W'(walk_p), 8'($urandom), 8'($urandom));
            end else if (sel < 80) begin
               send_beat(meteo_rof_pkg::KIND_SAMPLE, uptime + $urandom_range(1, 4),
                         12'($urandom), 10'($urandom), 14'($urandom), 8'($urandom),
                         8'($urandom));
            end else begin
               case ($urandom_range(9))
                  0, 1: code = 8'($urandom);
                  2, 3: code = meteo_rof_pkg::EVT_TEMP_RISE;
                  4, 5: code = meteo_rof_pkg::EVT_TEMP_FALL;
                  6, 7: code = meteo_rof_pkg::EVT_HUM_RISE;
                  default: code = meteo_rof_pkg::EVT_HUM_FALL;
               endcase
               // Aim the threshold between the last two driven values most of the time.
               if (code == meteo_rof_pkg::EVT_TEMP_RISE ||
                   code == meteo_rof_pkg::EVT_TEMP_FALL) begin
                  op = (prior_t + walk_t) / 20 + 127 + int'($urandom_range(2)) - 1;
               end else begin
                  op = (prior_h + walk_h) / 20 + 127 + int'($urandom_range(2)) - 1;
               end
               if ($urandom_range(3) == 0) op = $urandom_range(255);
               if (op > 255) op = 255;
               if (op < 0) op = 0;
               send_beat(meteo_rof_pkg::KIND_CHECK, $urandom, 12'($urandom), 10'($urandom),
                         14'($urandom), code, 8'(op));
            end
         end
      end

      drain();
      $display("checked %0d response beats over %0d register settings and three stall patterns",
               reports_checked, PHASES + 1);
      $display("seen %0d announcements and %0d scene crossings, %0d field mismatches",
               announce_seen, crossings_seen, mismatch_count);
      if (mismatch_count == 0 && reports_pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

/* meteo_report_on_change_filter_unit.f */
sv/meteo_rof_pkg.sv
sv/meteo_rof_prep.sv
sv/meteo_rof_core.sv
sv/meteo_report_on_change_filter_unit.sv
test/meteo_rof_checker.sv
test/meteo_report_on_change_filter_unit_tb.sv
